// ----- rtl/cos_search_pkg.sv -----
// Shared types and codes for the count-ordered self-organizing search table.
// No dependencies.
package cos_search_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SWAP
   } state_type;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_WIDTH  = 9;
   localparam int CFG_WIDTH   = 10;

endpackage

// ----- rtl/count_ordered_self_organizing_search.sv -----
// Top level: count-ordered self-organizing search table with a single-read-port table RAM.
// Depends on cos_search_pkg (state type, kind codes, field widths).
//
//   channel   ports                                       handshake
//   request   req_kind, req_slot, req_item_value          start & !busy
//   response  rsp_found, rsp_position                     rsp_strobe, one cycle
//   config    csr_entries_in_use                          csr_valid & csr_ready
//
// After reset the block clears all TABLE_DEPTH table entries, one per cycle, with
// busy high. A load's reply word comes out on the next cycle. A search reads the
// table RAM one entry per cycle and compares each word as it returns: a hit goes
// through the update state (and the swap state when the entry moves up) before its
// reply, a miss replies once the range is read out. The single RAM read port sets
// the scan rate. Responses cannot be stalled.
module count_ordered_self_organizing_search #(
   parameter int TABLE_DEPTH = 512,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic                                      req_kind,
   input  logic [cos_search_pkg::SLOT_WIDTH-1:0]     req_slot,
   input  logic signed [cos_search_pkg::VALUE_WIDTH-1:0] req_item_value,
   output logic                                      rsp_strobe,
   output logic                                      rsp_found,
   output logic [cos_search_pkg::SLOT_WIDTH-1:0]     rsp_position,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [cos_search_pkg::CFG_WIDTH-1:0]      csr_entries_in_use
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = AW + 1;
   localparam int VW = cos_search_pkg::VALUE_WIDTH;
   localparam int MW = VW + COUNT_WIDTH;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // table RAM: value in the high bits, count in the low bits
   logic [MW-1:0] table_mem [TABLE_DEPTH];
   logic [MW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [MW-1:0] wr_data;

   cos_search_pkg::state_type state_ff, state_in;

   logic [cos_search_pkg::CFG_WIDTH-1:0] entries_ff, entries_in;
   logic [IW-1:0]          limit_ff, limit_in;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic [AW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [VW-1:0]          key_ff, key_in;
   logic [MW-1:0]          prev_ff, prev_in;
   logic [AW-1:0]          hit_idx_ff, hit_idx_in;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, hit_cnt_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [cos_search_pkg::SLOT_WIDTH-1:0] rsp_position_ff, rsp_position_in;

   logic                   accept;
   logic                   issue;
   logic                   hit;
   logic [31:0]            slot_ext;
   logic [31:0]            limit_ext;
   logic [31:0]            hit_idx_ext;
   logic [COUNT_WIDTH-1:0] new_cnt;
   logic [COUNT_WIDTH-1:0] prev_cnt;
   logic                   do_swap;

   assign busy       = (state_ff != cos_search_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   assign slot_ext    = 32'(req_slot);
   assign limit_ext   = (32'(entries_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                             : 32'(entries_ff);
   assign hit_idx_ext = 32'(hit_idx_ff);

   assign issue    = (state_ff == cos_search_pkg::ST_SCAN) && (rd_idx_ff < limit_ff) && !hit;
   assign hit      = (state_ff == cos_search_pkg::ST_SCAN) && cmp_vld_ff
                     && (rd_data_ff[MW-1:COUNT_WIDTH] == key_ff);
   assign rd_addr  = rd_idx_ff[AW-1:0];

   // saturating increment and the move-up test, done in the update cycle
   assign new_cnt  = (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + 1'b1;
   assign prev_cnt = prev_ff[COUNT_WIDTH-1:0];
   assign do_swap  = (hit_idx_ff != '0) && (new_cnt > prev_cnt);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cos_search_pkg::ST_CLEAR;
         entries_ff    <= '0;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entries_ff    <= entries_in;
         rd_idx_ff     <= rd_idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff        <= limit_in;
      cmp_idx_ff      <= cmp_idx_in;
      key_ff          <= key_in;
      prev_ff         <= prev_in;
      hit_idx_ff      <= hit_idx_in;
      hit_cnt_ff      <= hit_cnt_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   always_comb begin
      state_in        = state_ff;
      entries_in      = entries_ff;
      limit_in        = limit_ff;
      rd_idx_in       = rd_idx_ff;
      cmp_idx_in      = cmp_idx_ff;
      cmp_vld_in      = 1'b0;
      key_in          = key_ff;
      prev_in         = prev_ff;
      hit_idx_in      = hit_idx_ff;
      hit_cnt_in      = hit_cnt_ff;
      rsp_strobe_in   = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      wr_en           = 1'b0;
      wr_addr         = rd_idx_ff[AW-1:0];
      wr_data         = '0;

      if (csr_valid && csr_ready) begin
         entries_in = csr_entries_in_use;
      end

      unique case (state_ff)
         cos_search_pkg::ST_CLEAR: begin
            wr_en     = 1'b1;
            wr_addr   = rd_idx_ff[AW-1:0];
            wr_data   = '0;
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = cos_search_pkg::ST_IDLE;
            end
         end
         cos_search_pkg::ST_IDLE: begin
            if (accept) begin
               key_in = VW'(req_item_value);
               if (req_kind == cos_search_pkg::KIND_LOAD) begin
                  // out-of-range slots are dropped but still answered
                  wr_en           = (slot_ext < 32'(TABLE_DEPTH));
                  wr_addr         = slot_ext[AW-1:0];
                  wr_data         = {VW'(req_item_value), {COUNT_WIDTH{1'b0}}};
                  rsp_strobe_in   = 1'b1;
                  rsp_found_in    = 1'b0;
                  rsp_position_in = '0;
               end else begin
                  limit_in  = limit_ext[IW-1:0];
                  rd_idx_in = '0;
                  state_in  = cos_search_pkg::ST_SCAN;
               end
            end
         end
         cos_search_pkg::ST_SCAN: begin
            if (issue) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               cmp_idx_in = rd_idx_ff[AW-1:0];
               cmp_vld_in = 1'b1;
            end
            if (hit) begin
               hit_idx_in = cmp_idx_ff;
               hit_cnt_in = rd_data_ff[COUNT_WIDTH-1:0];
               state_in   = cos_search_pkg::ST_UPDATE;
            end else if (cmp_vld_ff) begin
               // keep the entry just passed for a possible move-up
               prev_in = rd_data_ff;
            end else if (!issue) begin
               rsp_strobe_in   = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               state_in        = cos_search_pkg::ST_IDLE;
            end
         end
         cos_search_pkg::ST_UPDATE: begin
            wr_en           = 1'b1;
            wr_addr         = hit_idx_ff;
            hit_cnt_in      = new_cnt;
            rsp_found_in    = 1'b1;
            rsp_position_in = hit_idx_ext[cos_search_pkg::SLOT_WIDTH-1:0];
            if (do_swap) begin
               wr_data  = prev_ff;
               state_in = cos_search_pkg::ST_SWAP;
            end else begin
               wr_data       = {key_ff, new_cnt};
               rsp_strobe_in = 1'b1;
               state_in      = cos_search_pkg::ST_IDLE;
            end
         end
         cos_search_pkg::ST_SWAP: begin
            wr_en         = 1'b1;
            wr_addr       = hit_idx_ff - 1'b1;
            wr_data       = {key_ff, hit_cnt_ff};
            rsp_strobe_in = 1'b1;
            state_in      = cos_search_pkg::ST_IDLE;
         end
         default: begin
            state_in = cos_search_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for count_ordered_self_organizing_search.
// Needs cos_search_pkg and the block's RTL. A built-in table predictor checks
// every reply word against directed, random and hot-entry traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = cos_search_pkg::VALUE_WIDTH;
   localparam int SLOT_WIDTH = cos_search_pkg::SLOT_WIDTH;
   localparam int CFG_WIDTH = cos_search_pkg::CFG_WIDTH;
   localparam int TABLE_DEPTH = 512;
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_ITEMS = 600;
   localparam int HOT_HITS = 16;
   localparam logic [VALUE_WIDTH-1:0] FAR_VALUE = 32'h1234_5678;
   localparam logic [VALUE_WIDTH-1:0] HOT_VALUE = 32'h5A5A_5A5A;
   localparam logic [VALUE_WIDTH-1:0] COLD_VALUE = 32'hA5A5_A5A5;

   typedef struct {
      logic kind;
      logic [SLOT_WIDTH-1:0] slot;
      logic [VALUE_WIDTH-1:0] value;
      int gap;
   } request_type;

   typedef struct {
      logic found;
      logic [SLOT_WIDTH-1:0] position;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = cos_search_pkg::KIND_LOAD;
   logic [SLOT_WIDTH-1:0] req_slot = '0;
   logic signed [VALUE_WIDTH-1:0] req_item_value = '0;
   logic rsp_strobe;
   logic rsp_found;
   logic [SLOT_WIDTH-1:0] rsp_position;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CFG_WIDTH-1:0] csr_entries_in_use = '0;

   // predicted table contents and scan length
   logic [VALUE_WIDTH-1:0] slot_value [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] slot_count [TABLE_DEPTH];
   int unsigned scan_limit = 0;

   // stimulus side view of the table, used only to pick keys that should hit
   logic [VALUE_WIDTH-1:0] shadow_value [TABLE_DEPTH];

   request_type request_queue [$];
   reply_type expected_replies [$];
   request_type held_req;
   reply_type want;
   int gap_wait = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int random_items = 0;

   count_ordered_self_organizing_search #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COUNT_WIDTH(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_slot(req_slot),
      .req_item_value(req_item_value),
      .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_entries_in_use(csr_entries_in_use)
   );

   always #5 clock = ~clock;

   // Applies one request to the predicted table and returns the reply word.
   // A 9-bit slot never reaches past a 512-deep table, so every load lands.
   function automatic reply_type search_table_step(request_type r);
      reply_type rep;
      int unsigned n;
      int unsigned i;
      logic [VALUE_WIDTH-1:0] moved_value;
      logic [COUNT_BITS-1:0] moved_count;
      rep.found = 1'b0;
      rep.position = '0;
      if (r.kind == cos_search_pkg::KIND_LOAD) begin
         slot_value[r.slot] = r.value;
         slot_count[r.slot] = '0;
      end else begin
         n = (scan_limit > TABLE_DEPTH) ? TABLE_DEPTH : scan_limit;
         i = 0;
         while (i < n && slot_value[i] != r.value) i++;
         if (i < n) begin
            if (slot_count[i] != COUNT_CEIL) slot_count[i] = slot_count[i] + 1'b1;
            // strictly larger count moves the entry one slot toward the front
            if (i != 0 && slot_count[i] > slot_count[i-1]) begin
               moved_value = slot_value[i];
               moved_count = slot_count[i];
               slot_value[i] = slot_value[i-1];
               slot_count[i] = slot_count[i-1];
               slot_value[i-1] = moved_value;
               slot_count[i-1] = moved_count;
            end
            rep.found = 1'b1;
            rep.position = SLOT_WIDTH'(i);
         end
      end
      return rep;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pool_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0000_0001;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return 32'h5555_5555;
         6: return 32'hAAAA_AAAA;
         default: return 32'h0000_0007;
      endcase
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void queue_load(int s, logic [VALUE_WIDTH-1:0] v, int gap);
      request_type r;
      r.kind = cos_search_pkg::KIND_LOAD;
      r.slot = SLOT_WIDTH'(s);
      r.value = v;
      r.gap = gap;
      shadow_value[s] = v;
      request_queue.push_back(r);
   endfunction

   function automatic void queue_search(logic [VALUE_WIDTH-1:0] v, int gap);
      request_type r;
      r.kind = cos_search_pkg::KIND_SEARCH;
      r.slot = SLOT_WIDTH'($urandom_range(0, TABLE_DEPTH - 1));
      r.value = v;
      r.gap = gap;
      request_queue.push_back(r);
   endfunction

   function automatic void take_snapshot();
      foreach (slot_value[i]) shadow_value[i] = slot_value[i];
   endfunction

   // Mostly keys that sit in the scanned range, half of those near the front.
   function automatic logic [VALUE_WIDTH-1:0] pick_key(int lim);
      int pick;
      pick = $urandom_range(0, 99);
      if (lim > 0 && pick < 70) begin
         if (pick < 35) return shadow_value[$urandom_range(0, ((lim < 8) ? lim : 8) - 1)];
         return shadow_value[$urandom_range(0, lim - 1)];
      end
      if (pick < 85) return pool_value();
      return $urandom;
   endfunction

   task automatic wait_until_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || start || expected_replies.size() != 0);
   endtask

   task automatic write_scan_limit(int unsigned v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_entries_in_use <= CFG_WIDTH'(v);
      do @(posedge clock); while (csr_ready !== 1'b1);
      scan_limit = v;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase();
      int cfg;
      int lim;
      int len;
      int pick;
      int s;
      pick = $urandom_range(0, 99);
      if (pick < 40) cfg = $urandom_range(1, 16);
      else if (pick < 70) cfg = $urandom_range(17, 128);
      else if (pick < 78) cfg = 0;
      else if (pick < 88) cfg = $urandom_range(129, 511);
      else if (pick < 92) cfg = 512;
      else if (pick < 96) cfg = 1023;
      else cfg = $urandom_range(513, 1022);
      if ($urandom_range(0, 3) != 0) write_scan_limit(cfg);
      else cfg = scan_limit;
      lim = (cfg > TABLE_DEPTH) ? TABLE_DEPTH : cfg;
      // long scans are slow, keep those phases short
      len = (lim > 128) ? $urandom_range(3, 10) : $urandom_range(8, 40);
      take_snapshot();
      repeat (len) begin
         if ($urandom_range(0, 3) == 0) begin
            if (lim > 0 && $urandom_range(0, 9) < 7) s = $urandom_range(0, lim - 1);
            else s = $urandom_range(0, TABLE_DEPTH - 1);
            queue_load(s, ($urandom_range(0, 1) == 0) ? pool_value() : $urandom, random_gap());
         end else begin
            queue_search(pick_key(lim), random_gap());
         end
      end
      random_items += len;
      wait_until_idle();
   endtask

   task automatic present_request(request_type r);
      held_req = r;
      req_kind <= r.kind;
      req_slot <= r.slot;
      req_item_value <= r.value;
   endtask

   // driver: keeps start high across back-to-back words
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_wait <= 0;
      end else if (start) begin
         if (!busy) begin
            expected_replies.push_back(search_table_step(held_req));
            if (request_queue.size() != 0 && request_queue[0].gap == 0) begin
               present_request(request_queue.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end else if (request_queue.size() != 0) begin
         if (gap_wait < request_queue[0].gap) begin
            gap_wait <= gap_wait + 1;
         end else begin
            present_request(request_queue.pop_front());
            start <= 1'b1;
            gap_wait <= 0;
         end
      end
   end

   function automatic void log_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
   endfunction

   // monitor: reply words cannot be held off, take one per strobe
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            log_mismatch($sformatf("reply word with none expected: found=%0b position=%0d",
                                   rsp_found, rsp_position));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_found !== want.found || rsp_position !== want.position)
               log_mismatch($sformatf("expected found=%0b position=%0d, got found=%0b position=%0d",
                                      want.found, want.position, rsp_found, rsp_position));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      foreach (slot_value[i]) begin
         slot_value[i] = '0;
         slot_count[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty scan range misses, then fill the front with extreme values
      queue_search(32'h0000_0000, 0);
      queue_load(0, 32'h8000_0000, 0);
      queue_load(1, 32'h7FFF_FFFF, 1);
      queue_load(2, 32'h0000_0000, 0);
      queue_load(3, 32'hFFFF_FFFF, 0);
      queue_load(TABLE_DEPTH - 1, FAR_VALUE, 2);
      wait_until_idle();
      write_scan_limit(4);
      queue_search(32'h0000_0000, 0);
      queue_search(32'h0000_0000, 0);
      queue_search(32'h0000_0000, 0);
      queue_search(32'h8000_0000, 0);
      queue_search(32'h7FFF_FFFF, 0);   // ties with the word ahead, stays put
      queue_search(32'h7FFF_FFFF, 3);
      queue_search(32'hFFFF_FFFF, 0);
      queue_search(FAR_VALUE, 0);       // loaded past the scan range
      queue_search(32'h0000_002A, 0);
      queue_load(1, 32'hFFFF_FFFF, 0);  // duplicate: first match wins
      queue_search(32'hFFFF_FFFF, 0);
      wait_until_idle();

      // every slot gets written before any longer scan
      for (int s = 4; s < TABLE_DEPTH - 1; s++)
         queue_load(s, ($urandom_range(0, 3) == 0) ? pool_value() : $urandom, random_gap());
      wait_until_idle();
      take_snapshot();
      write_scan_limit(1023);
      queue_search(FAR_VALUE, random_gap());
      queue_search(shadow_value[$urandom_range(0, TABLE_DEPTH - 1)], random_gap());
      queue_search($urandom, random_gap());
      wait_until_idle();
      write_scan_limit(TABLE_DEPTH);
      queue_search(FAR_VALUE, 0);
      queue_search($urandom, 0);
      wait_until_idle();
      write_scan_limit(TABLE_DEPTH - 1);
      queue_search(FAR_VALUE, 0);
      wait_until_idle();

      while (random_items < RANDOM_ITEMS) run_random_phase();

      // slot 0 builds a lead in hits; the cold entry behind it must not move up
      write_scan_limit(2);
      queue_load(0, HOT_VALUE, 0);
      queue_load(1, COLD_VALUE, 0);
      repeat (HOT_HITS) queue_search(HOT_VALUE, 0);
      queue_search(COLD_VALUE, 0);
      queue_search(COLD_VALUE, 0);
      wait_until_idle();

      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cos_search_pkg.sv
rtl/count_ordered_self_organizing_search.sv
tb/tb_top.sv
